@@ rtl/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared constants, types and codes of the bracket balance checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    // Default stack size
    localparam int STACK_DEPTH_DEF = 16;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_OPEN_ROUND  = 8'h28;
    localparam logic [7:0] CH_CLOSE_ROUND = 8'h29;
    localparam logic [7:0] CH_OPEN_CURLY  = 8'h7B;
    localparam logic [7:0] CH_CLOSE_CURLY = 8'h7D;

    // Bracket kinds
    localparam logic KIND_ROUND = 1'b0;
    localparam logic KIND_CURLY = 1'b1;

    // Verdict codes
    localparam logic [1:0] VERDICT_BALANCED   = 2'd0;
    localparam logic [1:0] VERDICT_UNBALANCED = 2'd1;
    localparam logic [1:0] VERDICT_NONE       = 2'd2;
    localparam logic [1:0] VERDICT_OVERFLOW   = 2'd3;

    // Stack operation decoded by the front
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } t_op;

    // Command passed through the queue
    typedef struct packed {
        t_op  op;
        logic kind;
        logic is_last;
    } t_cmd;

    // Queue status seen by the front and by checks
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

@@ rtl/bbc_if.sv @@
// ----------------------------------------------------------------------------
// bbc_if
// Valid/ready channels for the input characters and the verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

// Input channel: one character per item
interface bbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// Output channel: one verdict per string
interface bbc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

@@ rtl/bbc_front.sv @@
// ----------------------------------------------------------------------------
// bbc_front
// Accepts characters and decodes them into stack commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_front (
    bbc_in_if.sink              i_in,
    input  bbc_pkg::t_q_status  i_q_status,
    output logic                o_push,
    output bbc_pkg::t_cmd       o_cmd
);

    // Take an item whenever the queue has room
    assign i_in.ready = !i_q_status.full;
    assign o_push     = i_in.valid && !i_q_status.full;

    // Character decode
    always_comb begin
        o_cmd.is_last = i_in.is_last;
        o_cmd.op      = bbc_pkg::OP_NONE;
        o_cmd.kind    = bbc_pkg::KIND_ROUND;
        unique case (i_in.char_code)
            bbc_pkg::CH_OPEN_ROUND: begin
                o_cmd.op = bbc_pkg::OP_OPEN;
            end
            bbc_pkg::CH_OPEN_CURLY: begin
                o_cmd.op   = bbc_pkg::OP_OPEN;
                o_cmd.kind = bbc_pkg::KIND_CURLY;
            end
            bbc_pkg::CH_CLOSE_ROUND: begin
                o_cmd.op = bbc_pkg::OP_CLOSE;
            end
            bbc_pkg::CH_CLOSE_CURLY: begin
                o_cmd.op   = bbc_pkg::OP_CLOSE;
                o_cmd.kind = bbc_pkg::KIND_CURLY;
            end
            default: begin
                o_cmd.op = bbc_pkg::OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/bbc_queue.sv @@
// ----------------------------------------------------------------------------
// bbc_queue
// Short command FIFO that decouples the decode front from the stack back.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bbc_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output bbc_pkg::t_cmd       o_cmd,
    output bbc_pkg::t_q_status  o_status
);

    bbc_pkg::t_cmd                     r_mem [bbc_pkg::QUEUE_DEPTH];
    logic [bbc_pkg::QUEUE_AW-1:0]      r_wr_ptr;
    logic [bbc_pkg::QUEUE_AW-1:0]      r_rd_ptr;
    logic [bbc_pkg::QUEUE_CW-1:0]      r_count;
    logic [bbc_pkg::QUEUE_CW-1:0]      n_count;

    // Status
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == bbc_pkg::QUEUE_CW'(bbc_pkg::QUEUE_DEPTH));
    assign o_cmd          = r_mem[r_rd_ptr];

    // Occupancy
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bbc_back.sv @@
// ----------------------------------------------------------------------------
// bbc_back
// Executes stack commands on a shift-line stack and registers the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_back #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bbc_pkg::t_cmd  i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    bbc_out_if.source      o_out
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    // Stack, top of stack in entry 0
    logic                r_stack [STACK_DEPTH];
    logic [DEPTH_W-1:0]  r_depth;
    logic [DEPTH_W-1:0]  n_depth;
    logic                r_failed;
    logic                n_failed;
    logic                r_overflow;
    logic                n_overflow;
    logic                r_seen;
    logic                n_seen;
    logic                r_out_valid;
    logic [1:0]          r_verdict;
    logic [1:0]          n_verdict;
    logic                take;
    logic                do_push;
    logic                do_pop;
    logic                frozen;

    assign o_cmd_ready   = !r_out_valid || o_out.ready;
    assign take          = i_cmd_valid && o_cmd_ready;
    assign frozen        = r_failed || r_overflow;
    assign o_out.valid   = r_out_valid;
    assign o_out.verdict = r_verdict;

    // Stack control and flags
    always_comb begin
        n_depth    = r_depth;
        n_failed   = r_failed;
        n_overflow = r_overflow;
        n_seen     = r_seen;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        if (take) begin
            case (i_cmd.op)
                bbc_pkg::OP_OPEN: begin
                    n_seen = 1'b1;
                    if (!frozen) begin
                        if (r_depth == DEPTH_W'(STACK_DEPTH)) begin
                            n_overflow = 1'b1;
                        end else begin
                            do_push = 1'b1;
                            n_depth = r_depth + 1'b1;
                        end
                    end
                end
                bbc_pkg::OP_CLOSE: begin
                    n_seen = 1'b1;
                    if (!frozen) begin
                        if (r_depth == '0) begin
                            n_failed = 1'b1;
                        end else begin
                            do_pop  = 1'b1;
                            n_depth = r_depth - 1'b1;
                            if (r_stack[0] != i_cmd.kind) begin
                                n_failed = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Verdict on the updated state
    always_comb begin
        if (n_overflow) begin
            n_verdict = bbc_pkg::VERDICT_OVERFLOW;
        end else if (n_failed) begin
            n_verdict = bbc_pkg::VERDICT_UNBALANCED;
        end else if (!n_seen) begin
            n_verdict = bbc_pkg::VERDICT_NONE;
        end else if (n_depth != '0) begin
            n_verdict = bbc_pkg::VERDICT_UNBALANCED;
        end else begin
            n_verdict = bbc_pkg::VERDICT_BALANCED;
        end
    end

    // Control state; cleared at the end of each string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_failed    <= 1'b0;
            r_overflow  <= 1'b0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (take && i_cmd.is_last) begin
            r_depth     <= '0;
            r_failed    <= 1'b0;
            r_overflow  <= 1'b0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b1;
        end else begin
            r_depth    <= n_depth;
            r_failed   <= n_failed;
            r_overflow <= n_overflow;
            r_seen     <= n_seen;
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Verdict payload
    always_ff @(posedge i_clk) begin
        if (take && i_cmd.is_last) begin
            r_verdict <= n_verdict;
        end
    end

    // Stack shift line: push shifts down, pop shifts up
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_stack[0] <= i_cmd.kind;
            for (int i = 1; i < STACK_DEPTH; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (do_pop) begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/bracket_balance_checker_unit.sv @@
// A verdict passes the command queue and then the verdict register after its
// last character is accepted. Throughput: one character per cycle while the
// queue is not full; the stack does a single shift per item.
// Reset: synchronous, active low; clears queue, depth, flags and output valid.
// Stack contents are not reset; entries above the depth are never read.
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit
// Checks round and curly bracket nesting per string, one verdict per string.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker_unit #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bbc_in_if.sink      i_in,
    bbc_out_if.source   o_out
);

    bbc_pkg::t_cmd       front_cmd;
    bbc_pkg::t_cmd       q_cmd;
    bbc_pkg::t_q_status  q_status;
    logic                push;
    logic                pop;
    logic                back_ready;

    assign pop = !q_status.empty && back_ready;

    // Decode front
    bbc_front u_front (
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    // Command queue
    bbc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (q_cmd),
        .o_status (q_status)
    );

    // Stack back end
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (!q_status.empty),
        .o_cmd_ready (back_ready),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // Queue can never report empty and full together
    a_q_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.empty && q_status.full))
        else $error("queue empty and full at once");

    // A pushed command is visible in the queue on the next cycle
    a_push_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !q_status.empty)
        else $error("queue empty after push");

    // A new verdict only follows a last command taken by the back end
    a_verdict_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(pop && q_cmd.is_last))
        else $error("verdict without end of string");

    // Input is refused only while the queue is full
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> q_status.full)
        else $error("input stalled with queue room");
`endif

endmodule

`default_nettype wire

@@ verif/bracket_balance_checker_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit_checker
// Watches the character and verdict channels, tracks the bracket stack of
// each string on its own and compares every verdict with the one it predicts.
// ----------------------------------------------------------------------------

module bracket_balance_checker_unit_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bbc_in_if    i_chars,
    bbc_out_if   i_verdicts,
    output int   o_fail_count,
    output int   o_pending
);

    // Shadow of the bracket stack for the string in progress
    logic       kind_stack [0:STACK_DEPTH-1];
    int         depth;
    bit         failed;
    bit         overflowed;
    bit         bracket_seen;

    // Verdicts owed by the block, oldest first
    logic [1:0] verdicts_due [$];

    task automatic clear_string();
        depth        = 0;
        failed       = 1'b0;
        overflowed   = 1'b0;
        bracket_seen = 1'b0;
    endtask

    // Push or pop for one character; anything but a bracket is ignored
    task automatic track_char(input logic [7:0] ch);
        logic is_bracket;
        logic is_open;
        logic kind;
        is_bracket = 1'b1;
        is_open    = 1'b0;
        kind       = KIND_ROUND;
        case (ch)
            CH_OPEN_ROUND: begin
                is_open = 1'b1;
            end
            CH_OPEN_CURLY: begin
                is_open = 1'b1;
                kind    = KIND_CURLY;
            end
            CH_CLOSE_ROUND: begin
                kind = KIND_ROUND;
            end
            CH_CLOSE_CURLY: begin
                kind = KIND_CURLY;
            end
            default: begin
                is_bracket = 1'b0;
            end
        endcase
        if (is_bracket) begin
            bracket_seen = 1'b1;
            // stack is frozen once the string has gone wrong
            if (!failed && !overflowed) begin
                if (is_open) begin
                    if (depth >= STACK_DEPTH) begin
                        overflowed = 1'b1;
                    end else begin
                        kind_stack[depth] = kind;
                        depth++;
                    end
                end else if (depth == 0) begin
                    failed = 1'b1;
                end else begin
                    depth--;
                    if (kind_stack[depth] != kind) begin
                        failed = 1'b1;
                    end
                end
            end
        end
    endtask

    // Overflow wins, then a failure, then no bracket, then leftover opens
    function automatic logic [1:0] string_verdict();
        if (overflowed) return VERDICT_OVERFLOW;
        if (failed) return VERDICT_UNBALANCED;
        if (!bracket_seen) return VERDICT_NONE;
        if (depth != 0) return VERDICT_UNBALANCED;
        return VERDICT_BALANCED;
    endfunction

    // Compare verdicts first, then account for the item taken at this edge
    always @(posedge i_clk) begin : watch
        logic [1:0] want;
        if (!i_rst_n) begin
            clear_string();
            verdicts_due.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_verdicts.valid && i_verdicts.ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("verdict: expected none, actual %0d", i_verdicts.verdict);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = verdicts_due.pop_front();
                    if (want !== i_verdicts.verdict) begin
                        $error("verdict: expected %0d, actual %0d", want, i_verdicts.verdict);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_chars.valid && i_chars.ready) begin
                track_char(i_chars.char_code);
                if (i_chars.is_last) begin
                    verdicts_due.push_back(string_verdict());
                    clear_string();
                end
            end
            o_pending <= verdicts_due.size();
        end
    end

endmodule

@@ verif/bracket_balance_checker_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit_tb
// Feeds strings of characters to the bracket balance checker: a directed set
// of corner strings, then random nested, deep, overflowing, broken and noise
// strings, with random idle cycles on both channels. A checker beside the
// block predicts and compares every verdict.
// ----------------------------------------------------------------------------

module bracket_balance_checker_unit_tb;
    import bbc_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic       clk = 1'b0;
    logic       rst_n;
    int         fail_count;
    int         pending;
    int         items_sent;
    int         idle_cycles;
    bit         sender_calm;
    bit         recv_calm;
    logic [7:0] text_q [$];

    bbc_in_if  in_ch ();
    bbc_out_if out_ch ();

    bracket_balance_checker_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bracket_balance_checker_unit_checker checker_0 (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_chars      (in_ch),
        .i_verdicts   (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 clk = ~clk;

    // Abort when neither channel moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic logic [7:0] pick_bracket();
        case ($urandom_range(0, 3))
            0:       return CH_OPEN_ROUND;
            1:       return CH_CLOSE_ROUND;
            2:       return CH_OPEN_CURLY;
            default: return CH_CLOSE_CURLY;
        endcase
    endfunction

    // Valid stays high between back-to-back items
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_code <= ch;
        in_ch.is_last   <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text();
        sender_calm = ($urandom_range(0, 3) == 0);
        foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    endtask

    // Hold the sender until every owed verdict has come out
    task automatic drain_verdicts();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Random string: mostly nested brackets with filler, some of them broken
    task automatic build_string();
        int   sel;
        int   cap;
        int   opens_left;
        int   idx;
        bit   greedy;
        logic kind;
        logic kinds [$];
        text_q.delete();
        sel = $urandom_range(0, 15);
        if (sel < 2) begin
            // short fragment of raw bytes and stray brackets
            repeat ($urandom_range(1, 6)) begin
                text_q.push_back($urandom_range(0, 1) ? pick_bracket()
                                                      : 8'($urandom_range(0, 255)));
            end
        end else begin
            greedy = 1'b0;
            if (sel < 11) begin
                cap = $urandom_range(1, 6);
            end else if (sel < 14) begin
                cap    = STACK_DEPTH_DEF;
                greedy = 1'b1;
            end else begin
                cap    = STACK_DEPTH_DEF + $urandom_range(1, 4);
                greedy = 1'b1;
            end
            opens_left = greedy ? cap + $urandom_range(0, 3) : $urandom_range(1, 8);
            while (opens_left > 0 || kinds.size() > 0) begin
                if ($urandom_range(0, 3) == 0) text_q.push_back(8'($urandom_range(0, 255)));
                if (opens_left > 0 && (kinds.size() == 0 ||
                    (kinds.size() < cap && (greedy || $urandom_range(0, 1) == 1)))) begin
                    kind = 1'($urandom_range(0, 1));
                    kinds.push_back(kind);
                    text_q.push_back(kind == KIND_CURLY ? CH_OPEN_CURLY : CH_OPEN_ROUND);
                    opens_left--;
                end else begin
                    kind = kinds.pop_back();
                    text_q.push_back(kind == KIND_CURLY ? CH_CLOSE_CURLY : CH_CLOSE_ROUND);
                end
            end
            // corrupt about a quarter of the well-formed strings
            if ($urandom_range(0, 3) == 0) begin
                idx = $urandom_range(0, text_q.size() - 1);
                case ($urandom_range(0, 2))
                    0:       text_q[idx] = pick_bracket();
                    1:       text_q.delete(idx);
                    default: text_q.insert(idx, pick_bracket());
                endcase
            end
            if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver: random stall per verdict, with calm stretches
    initial begin
        out_ch.ready <= 1'b0;
        recv_calm = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin : recv_loop
            int gap;
            if ($urandom_range(0, 19) == 0) recv_calm = !recv_calm;
            gap = draw_wait(recv_calm);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.char_code <= 8'h00;
        in_ch.is_last   <= 1'b0;
        rst_n           <= 1'b0;
        items_sent  = 0;
        sender_calm = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: no brackets (zero byte, all-ones byte), both pairs,
        // kind mismatch, close on empty stack, leftover open, overflow
        text_q = '{8'h00};
        send_text();
        text_q = '{CH_OPEN_ROUND, CH_CLOSE_ROUND};
        send_text();
        text_q = '{CH_OPEN_CURLY, CH_CLOSE_CURLY};
        send_text();
        text_q = '{CH_OPEN_ROUND, CH_CLOSE_CURLY};
        send_text();
        text_q = '{CH_CLOSE_CURLY};
        send_text();
        text_q = '{CH_OPEN_CURLY};
        send_text();
        text_q = '{8'hFF};
        send_text();
        text_q.delete();
        for (int i = 0; i <= STACK_DEPTH_DEF; i++) begin
            text_q.push_back(i % 2 ? CH_OPEN_CURLY : CH_OPEN_ROUND);
        end
        send_text();
        drain_verdicts();

        // Random strings, now and then waiting for the block to empty
        while (items_sent < RANDOM_ITEMS) begin
            build_string();
            send_text();
            if ($urandom_range(0, 15) == 0) drain_verdicts();
        end

        drain_verdicts();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
